### rtl/core/mtm_pkg.sv
package mtm_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam logic [31:0] FAR_LIMIT = 32'h0FFF_FFFF;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_ALLOC = 3'd1;
    localparam logic [2:0] MODE_FREE  = 3'd2;
    localparam logic [2:0] MODE_BIND  = 3'd3;
    localparam logic [2:0] MODE_ARM   = 3'd4;
    localparam logic [2:0] MODE_CANCEL = 3'd5;
    localparam logic [2:0] MODE_CALL  = 3'd6;

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_MSG  = 2'd1;
    localparam logic [1:0] KIND_SW   = 2'd2;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_ARMED = 2'd2;

    localparam logic [1:0] SCAN_MARK = 2'd0;
    localparam logic [1:0] SCAN_SEL  = 2'd1;
    localparam logic [1:0] SCAN_CALL = 2'd2;

    typedef struct packed {
        logic          capture;
        logic          exec;
        logic          tick_start;
        logic          scan_init;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          proc;
        logic [AW-1:0] proc_addr;
        logic [1:0]    scan_op;
        logic          pick;
        logic          final_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       found;
        logic       best_task;
        logic       cnt_one;
        logic       cnt_zero;
        logic       need_final;
    } t_stat;

endpackage

### rtl/core/mtm_in_if.sv
interface mtm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  slot;
    logic [31:0] delay;
    logic [7:0]  owner;
    logic signed [31:0] message;
    logic        auto_cancel;

    modport source (output valid, mode, slot, delay, owner, message, auto_cancel,
                    input ready);
    modport sink   (input valid, mode, slot, delay, owner, message, auto_cancel,
                    output ready);
endinterface

### rtl/core/mtm_out_if.sv
interface mtm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  slot_out;
    logic        ok;
    logic [7:0]  owner_out;
    logic signed [31:0] message_out;
    logic        last;

    modport source (output valid, kind, slot_out, ok, owner_out, message_out, last,
                    input ready);
    modport sink   (input valid, kind, slot_out, ok, owner_out, message_out, last,
                    output ready);
endinterface

### rtl/core/mtm_cfg_if.sv
interface mtm_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] task_slot;

    modport source (output valid, task_slot, input ready);
    modport sink   (input valid, task_slot, output ready);
endinterface

### rtl/core/multi_timer_manager.sv
// Timer slot manager driven by one tick counter.
// i_in carries one command item: tick, allocate, free, bind, arm, cancel or
// cancel-all-of-owner. o_out returns the result items of each command, the
// final one flagged by last. i_cfg writes the task slot and is always ready;
// write it only while the block is idle.
// Simple commands capture the item, execute it in a decode state and present
// the registered result in the output state. Cancel-all walks every slot
// through the table read port. A tick first walks all slots to mark expired
// ones, then one further walk per expired slot picks the next deadline.
// All walks go through the single read port of the slot tables.
// One item is handled at a time: i_in is ready only once the last result
// of the previous item has been taken. A stalled receiver holds the result
// register and the walk waits. Reset frees every slot, clears the tick and
// arm counters and sets the task slot to none; no clearing pass is needed.
module multi_timer_manager (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mtm_in_if.sink   i_in,
    mtm_out_if.source o_out,
    mtm_cfg_if.sink  i_cfg
);

    mtm_pkg::t_cmd  cmd;
    mtm_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    mtm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mtm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_in.mode),
        .i_slot        (i_in.slot),
        .i_delay       (i_in.delay),
        .i_owner       (i_in.owner),
        .i_message     (i_in.message),
        .i_auto_cancel (i_in.auto_cancel),
        .i_cfg_we      (i_cfg.valid),
        .i_task_slot   (i_cfg.task_slot),
        .o_kind        (o_out.kind),
        .o_slot_out    (o_out.slot_out),
        .o_ok          (o_out.ok),
        .o_owner_out   (o_out.owner_out),
        .o_message_out (o_out.message_out),
        .o_last        (o_out.last)
    );

endmodule

### rtl/core/mtm_datapath.sv
module mtm_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mtm_pkg::t_cmd         i_cmd,
    output mtm_pkg::t_stat        o_stat,
    input  logic [2:0]            i_mode,
    input  logic [4:0]            i_slot,
    input  logic [31:0]           i_delay,
    input  logic [7:0]            i_owner,
    input  logic signed [31:0]    i_message,
    input  logic                  i_auto_cancel,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_task_slot,
    output logic [1:0]            o_kind,
    output logic [4:0]            o_slot_out,
    output logic                  o_ok,
    output logic [7:0]            o_owner_out,
    output logic signed [31:0]    o_message_out,
    output logic                  o_last
);

    localparam int N  = mtm_pkg::NUM_SLOTS;
    localparam int AW = mtm_pkg::AW;
    localparam int CW = mtm_pkg::CNT_W;

    logic [7:0]  mem_owner [N];
    logic [31:0] mem_msg   [N];
    logic [31:0] mem_dl    [N];
    logic [31:0] mem_ord   [N];

    logic [7:0]  r_rd_owner;
    logic [31:0] r_rd_msg, r_rd_dl, r_rd_ord;

    logic [1:0]  r_status [N];
    logic        r_auto   [N];
    logic        r_pend   [N];

    logic [31:0] r_tick, r_seq;
    logic [5:0]  r_task;

    logic [2:0]  r_mode;
    logic [4:0]  r_slot;
    logic [31:0] r_delay;
    logic [7:0]  r_owner;
    logic [31:0] r_msg;
    logic        r_auto_in;

    logic [CW-1:0] r_cnt;
    logic        r_sw, r_emit, r_found;
    logic [AW-1:0] r_best;
    logic [31:0] r_best_dl, r_best_ord, r_best_msg;
    logic [7:0]  r_best_owner;

    logic [1:0]  r_kind;
    logic [4:0]  r_slot_out;
    logic        r_ok, r_last;
    logic [7:0]  r_owner_out;
    logic [31:0] r_msg_out;

    logic          slot_ok;
    logic [AW-1:0] saddr;
    logic          free_found;
    logic [AW-1:0] free_idx;
    logic          best_task;
    logic [1:0]    pst;
    logic          better;

    assign slot_ok = 32'(r_slot) < 32'(N);
    assign saddr   = AW'(r_slot);
    assign best_task = 32'(r_best) == 32'(r_task);
    assign pst     = r_status[i_cmd.proc_addr];
    assign better  = !r_found || (r_rd_dl < r_best_dl) ||
                     ((r_rd_dl == r_best_dl) && (r_rd_ord > r_best_ord));

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_status[i] == mtm_pkg::ST_FREE) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.found      = r_found;
    assign o_stat.best_task  = best_task;
    assign o_stat.cnt_one    = r_cnt == CW'(1);
    assign o_stat.cnt_zero   = r_cnt == '0;
    assign o_stat.need_final = r_sw || !r_emit;

    // Slot tables; owner and message only change on bind, deadline and order on arm.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && slot_ok && r_mode == mtm_pkg::MODE_BIND) begin
            mem_owner[saddr] <= r_owner;
            mem_msg[saddr]   <= r_msg;
        end
        if (i_cmd.exec && slot_ok && r_mode == mtm_pkg::MODE_ARM &&
            r_status[saddr] != mtm_pkg::ST_FREE) begin
            mem_dl[saddr]  <= r_tick + r_delay;
            mem_ord[saddr] <= r_seq + 32'd1;
        end
        if (i_cmd.rd_en) begin
            r_rd_owner <= mem_owner[i_cmd.rd_addr];
            r_rd_msg   <= mem_msg[i_cmd.rd_addr];
            r_rd_dl    <= mem_dl[i_cmd.rd_addr];
            r_rd_ord   <= mem_ord[i_cmd.rd_addr];
        end
    end

    // Captured item and payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_slot    <= i_slot;
            r_delay   <= i_delay;
            r_owner   <= i_owner;
            r_msg     <= i_message;
            r_auto_in <= i_auto_cancel;
        end
        if (i_cmd.proc && i_cmd.scan_op == mtm_pkg::SCAN_SEL &&
            r_pend[i_cmd.proc_addr] && better) begin
            r_best       <= i_cmd.proc_addr;
            r_best_dl    <= r_rd_dl;
            r_best_ord   <= r_rd_ord;
            r_best_owner <= r_rd_owner;
            r_best_msg   <= r_rd_msg;
        end
        if (i_cmd.exec) begin
            r_kind      <= mtm_pkg::KIND_DONE;
            r_slot_out  <= '0;
            r_ok        <= 1'b0;
            r_owner_out <= '0;
            r_msg_out   <= '0;
            r_last      <= 1'b1;
            if (r_mode == mtm_pkg::MODE_ALLOC && free_found) begin
                r_slot_out <= 5'(free_idx);
                r_ok       <= 1'b1;
            end
            if (r_mode == mtm_pkg::MODE_CANCEL && slot_ok &&
                r_status[saddr] == mtm_pkg::ST_ARMED) begin
                r_ok <= 1'b1;
            end
        end
        if (i_cmd.pick && r_found && !best_task) begin
            r_kind      <= mtm_pkg::KIND_MSG;
            r_slot_out  <= 5'(r_best);
            r_ok        <= 1'b0;
            r_owner_out <= r_best_owner;
            r_msg_out   <= r_best_msg;
            r_last      <= (r_cnt == CW'(1)) && !r_sw;
        end
        if (i_cmd.final_load) begin
            r_kind      <= r_sw ? mtm_pkg::KIND_SW : mtm_pkg::KIND_DONE;
            r_slot_out  <= r_sw ? 5'(r_task) : 5'd0;
            r_ok        <= 1'b0;
            r_owner_out <= '0;
            r_msg_out   <= '0;
            r_last      <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_seq   <= '0;
            r_task  <= 6'd32;
            r_cnt   <= '0;
            r_sw    <= 1'b0;
            r_emit  <= 1'b0;
            r_found <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_status[i] <= mtm_pkg::ST_FREE;
                r_auto[i]   <= 1'b0;
                r_pend[i]   <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_task <= i_task_slot;
            end
            if (i_cmd.exec) begin
                unique case (r_mode)
                    mtm_pkg::MODE_ALLOC: begin
                        if (free_found) begin
                            r_status[free_idx] <= mtm_pkg::ST_ALLOC;
                            r_auto[free_idx]   <= 1'b0;
                        end
                    end
                    mtm_pkg::MODE_FREE: begin
                        if (slot_ok) begin
                            r_status[saddr] <= mtm_pkg::ST_FREE;
                        end
                    end
                    mtm_pkg::MODE_BIND: begin
                        if (slot_ok) begin
                            r_auto[saddr] <= r_auto_in;
                        end
                    end
                    mtm_pkg::MODE_ARM: begin
                        if (slot_ok && r_status[saddr] != mtm_pkg::ST_FREE) begin
                            r_status[saddr] <= mtm_pkg::ST_ARMED;
                            r_seq           <= r_seq + 32'd1;
                        end
                    end
                    mtm_pkg::MODE_CANCEL: begin
                        if (slot_ok && r_status[saddr] == mtm_pkg::ST_ARMED) begin
                            r_status[saddr] <= mtm_pkg::ST_ALLOC;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick_start) begin
                r_tick <= r_tick + 32'd1;
                r_cnt  <= '0;
                r_sw   <= 1'b0;
                r_emit <= 1'b0;
                for (int i = 0; i < N; i++) begin
                    r_pend[i] <= 1'b0;
                end
            end
            if (i_cmd.scan_init) begin
                r_found <= 1'b0;
            end
            if (i_cmd.proc) begin
                unique case (i_cmd.scan_op)
                    mtm_pkg::SCAN_MARK: begin
                        if (pst == mtm_pkg::ST_ARMED && r_rd_dl <= mtm_pkg::FAR_LIMIT &&
                            r_rd_dl <= r_tick) begin
                            r_pend[i_cmd.proc_addr] <= 1'b1;
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                    mtm_pkg::SCAN_SEL: begin
                        if (r_pend[i_cmd.proc_addr] && better) begin
                            r_found <= 1'b1;
                        end
                    end
                    mtm_pkg::SCAN_CALL: begin
                        if (pst != mtm_pkg::ST_FREE && r_auto[i_cmd.proc_addr] &&
                            r_rd_owner == r_owner) begin
                            r_status[i_cmd.proc_addr] <= mtm_pkg::ST_FREE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.pick && r_found) begin
                r_status[r_best] <= mtm_pkg::ST_ALLOC;
                r_pend[r_best]   <= 1'b0;
                r_cnt            <= r_cnt - CW'(1);
                if (best_task) begin
                    r_sw <= 1'b1;
                end else begin
                    r_emit <= 1'b1;
                end
            end
        end
    end

    assign o_kind        = r_kind;
    assign o_slot_out    = r_slot_out;
    assign o_ok          = r_ok;
    assign o_owner_out   = r_owner_out;
    assign o_message_out = r_msg_out;
    assign o_last        = r_last;

endmodule

### rtl/core/mtm_ctrl.sv
module mtm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  mtm_pkg::t_stat i_stat,
    output mtm_pkg::t_cmd  o_cmd
);

    localparam int N  = mtm_pkg::NUM_SLOTS;
    localparam int AW = mtm_pkg::AW;
    localparam int CW = mtm_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_proc, n_proc;
    logic [AW-1:0] r_paddr, n_paddr;
    logic [1:0]    r_scan, n_scan;
    logic          rd_en;

    assign rd_en = (r_state == S_SCAN) && (32'(r_idx) < 32'(N));

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        n_proc  = 1'b0;
        n_paddr = r_paddr;
        n_scan  = r_scan;
        o_cmd   = '0;
        o_cmd.rd_addr   = AW'(r_idx);
        o_cmd.proc_addr = r_paddr;
        o_cmd.scan_op   = r_scan;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_idx = '0;
                if (i_stat.mode == mtm_pkg::MODE_TICK) begin
                    o_cmd.tick_start = 1'b1;
                    o_cmd.scan_init  = 1'b1;
                    n_scan  = mtm_pkg::SCAN_MARK;
                    n_state = S_SCAN;
                end else if (i_stat.mode == mtm_pkg::MODE_CALL) begin
                    n_scan  = mtm_pkg::SCAN_CALL;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_ret   = S_IDLE;
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                // Read data is registered and arrives in the cycle after its address, so
                // each entry is judged in the cycle after the counter passes it.
                o_cmd.rd_en = rd_en;
                o_cmd.proc  = r_proc;
                n_proc  = rd_en;
                n_paddr = AW'(r_idx);
                if (rd_en) begin
                    n_idx = r_idx + CW'(1);
                end else if (!r_proc) begin
                    unique case (r_scan)
                        mtm_pkg::SCAN_MARK: begin
                            if (i_stat.cnt_zero) begin
                                n_state = S_FINAL;
                            end else begin
                                o_cmd.scan_init = 1'b1;
                                n_idx   = '0;
                                n_scan  = mtm_pkg::SCAN_SEL;
                                n_state = S_SCAN;
                            end
                        end
                        mtm_pkg::SCAN_SEL: begin
                            n_state = S_PICK;
                        end
                        default: begin
                            o_cmd.exec = 1'b1;
                            n_ret   = S_IDLE;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                if (!i_stat.found) begin
                    n_state = S_FINAL;
                end else begin
                    n_ret = i_stat.cnt_one ? S_FINAL : S_SCAN;
                    n_idx = '0;
                    o_cmd.scan_init = 1'b1;
                    n_state = i_stat.best_task ? n_ret : S_OUT;
                end
            end
            S_FINAL: begin
                o_cmd.final_load = 1'b1;
                n_ret   = S_IDLE;
                n_state = i_stat.need_final ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_idx   <= '0;
            r_proc  <= 1'b0;
            r_paddr <= '0;
            r_scan  <= mtm_pkg::SCAN_MARK;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
            r_proc  <= n_proc;
            r_paddr <= n_paddr;
            r_scan  <= n_scan;
        end
    end

endmodule
